// ----- design/aptc_pkg.sv -----
// ----------------------------------------------------------------------------
// aptc_pkg
// Types, widths and constants shared by the period timestamp clock modules.
// ----------------------------------------------------------------------------
package aptc_pkg;

	localparam int TIME_W = 64;
	localparam int TICK_W = 32;
	localparam int RATE_W = 21;
	localparam int PER_W  = 16;

	// shared multiplier: A up to three 32-bit limbs, B one limb
	localparam int MA_W   = 96;
	localparam int MB_W   = 32;
	localparam int ACC_W  = MA_W + MB_W;

	// bit-serial divider
	localparam int NUM_W  = 96;
	localparam int DEN_W  = PER_W + TICK_W;
	localparam int DCNT_W = $clog2(NUM_W);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_ANCHOR = 2'd0;
	localparam logic [IDX_W-1:0] REG_TICKS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_RATE   = 2'd2;
	localparam logic [IDX_W-1:0] REG_PERIOD = 2'd3;

	localparam logic [TIME_W-1:0] ANCHOR_RST = '0;
	localparam logic [TICK_W-1:0] TICKS_RST  = 32'd24000000;
	localparam logic [RATE_W-1:0] RATE_RST   = 21'd48000;
	localparam logic [PER_W-1:0]  PERIOD_RST = 16'd512;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_PT_MUL,
		ST_D_MUL,
		ST_I_DIV,
		ST_S_MUL,
		ST_SAT_DIV,
		ST_SAT_MUL,
		ST_Q_MUL,
		ST_Q_DIV,
		ST_Q_CHECK,
		ST_H_START,
		ST_H_MUL,
		ST_H_DIV,
		ST_OUT_WAIT
	} state_t;

	typedef enum logic [2:0] {
		MA_DIFF,
		MA_TICKS,
		MA_QUO,
		MA_NXT,
		MA_CUR
	} mul_a_sel_t;

	typedef enum logic [1:0] {
		MB_RATE,
		MB_PERIOD,
		MB_TICKS
	} mul_b_sel_t;

	typedef enum logic {
		DN_ACC,
		DN_ONES
	} div_num_sel_t;

	typedef enum logic [1:0] {
		DD_PT,
		DD_RATE,
		DD_PERIOD
	} div_den_sel_t;

	typedef struct packed {
		logic         load_in;
		logic         mul_start;
		mul_a_sel_t   mul_a;
		mul_b_sel_t   mul_b;
		logic         div_start;
		div_num_sel_t div_num;
		div_den_sel_t div_den;
		logic         pt_load;
		logic         rs_commit;
		logic         adv_commit;
		logic         out_load;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic rs_ok;
		logic q_ok;
		logic adv_ok;
		logic s_ovf;
		logic rate_zero;
		logic mul_done;
		logic div_done;
	} stat_t;

endpackage

// ----- design/aptc_mul.sv -----
// ----------------------------------------------------------------------------
// aptc_mul
// Multicycle 96x32 multiplier: one 32x32 partial product per cycle,
// accumulated into a 128-bit result.
// ----------------------------------------------------------------------------
module aptc_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [aptc_pkg::MA_W-1:0] a,
	input  logic [aptc_pkg::MB_W-1:0] b,
	output logic                      done,
	output logic [aptc_pkg::ACC_W-1:0] acc
);
	import aptc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [1:0]        step_q;
	logic [MA_W-1:0]   a_q;
	logic [MB_W-1:0]   b_q;
	logic [2*MB_W-1:0] prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [MB_W-1:0]   limb;
	logic [ACC_W-1:0]  shifted;

	always_comb begin
		case (step_q)
			2'd0:    limb = a_q[31:0];
			2'd1:    limb = a_q[63:32];
			default: limb = a_q[95:64];
		endcase
		// product from the previous step lands at that step's limb offset
		case (step_q)
			2'd1:    shifted = {64'd0, prod_q};
			2'd2:    shifted = {32'd0, prod_q, 32'd0};
			2'd3:    shifted = {prod_q, 64'd0};
			default: shifted = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != 2'd3)
				prod_q <= {{MB_W{1'b0}}, limb} * {{MB_W{1'b0}}, b_q};
			if (step_q != 2'd0)
				acc_q <= acc_q + shifted;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ----- design/aptc_div.sv -----
// ----------------------------------------------------------------------------
// aptc_div
// Restoring divider, 96-bit dividend by 48-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module aptc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [aptc_pkg::NUM_W-1:0] num,
	input  logic [aptc_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [aptc_pkg::NUM_W-1:0] quo
);
	import aptc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]  nq_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	// dividend shifts out the top while quotient bits shift in at the bottom
	always_comb begin
		trial = {rem_q, nq_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DCNT_W'(NUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(NUM_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

// ----- design/aptc_dpath.sv -----
// ----------------------------------------------------------------------------
// aptc_dpath
// Configuration registers, published sample time, operand selection for the
// shared multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
module aptc_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [aptc_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [aptc_pkg::DATA_W-1:0] cfg_wdata,
	output logic [aptc_pkg::DATA_W-1:0] cfg_rdata,
	input  logic                        mode,
	input  logic [aptc_pkg::TIME_W-1:0] current_host_time,
	input  aptc_pkg::cmd_t              cmd,
	output aptc_pkg::stat_t             stat,
	output logic [aptc_pkg::TIME_W-1:0] sample_time,
	output logic [aptc_pkg::TIME_W-1:0] host_time,
	output logic                        advanced
);
	import aptc_pkg::*;

	logic [TIME_W-1:0] anchor_q;
	logic [TICK_W-1:0] ticks_q;
	logic [RATE_W-1:0] rate_q;
	logic [PER_W-1:0]  period_q;
	logic [TIME_W-1:0] pub_q;
	logic              adv_q;
	logic              mode_q;
	logic [TIME_W-1:0] now_q;
	logic [DEN_W-1:0]  pt_q;
	logic [TIME_W-1:0] sample_q;
	logic [TIME_W-1:0] host_q;
	logic              advanced_q;

	logic [MA_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic              mul_done;
	logic [ACC_W-1:0]  acc;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [NUM_W-1:0]  quo;

	logic [TIME_W:0]   nxt_sum;
	logic [TIME_W:0]   bnd_sum;
	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] target;
	logic              p_nz;
	logic              t_nz;
	logic              r_nz;

	assign p_nz    = period_q != '0;
	assign t_nz    = ticks_q != '0;
	assign r_nz    = rate_q != '0;
	assign diff    = now_q - anchor_q;
	assign nxt_sum = {1'b0, pub_q} + {{(TIME_W+1-PER_W){1'b0}}, period_q};
	assign bnd_sum = {1'b0, anchor_q} + {1'b0, quo[TIME_W-1:0]};
	assign target  = acc[TIME_W-1:0];

	always_comb begin
		case (cmd.mul_a)
			MA_DIFF:  mul_a = {{(MA_W-TIME_W){1'b0}}, diff};
			MA_TICKS: mul_a = {{(MA_W-TICK_W){1'b0}}, ticks_q};
			MA_QUO:   mul_a = quo;
			MA_NXT:   mul_a = {{(MA_W-TIME_W){1'b0}}, nxt_sum[TIME_W-1:0]};
			MA_CUR:   mul_a = {{(MA_W-TIME_W){1'b0}}, pub_q};
			default:  mul_a = '0;
		endcase
		case (cmd.mul_b)
			MB_RATE:   mul_b = {{(MB_W-RATE_W){1'b0}}, rate_q};
			MB_PERIOD: mul_b = {{(MB_W-PER_W){1'b0}}, period_q};
			MB_TICKS:  mul_b = ticks_q;
			default:   mul_b = '0;
		endcase
		case (cmd.div_num)
			DN_ACC:  div_num = acc[NUM_W-1:0];
			DN_ONES: div_num = {{(NUM_W-TIME_W){1'b0}}, {TIME_W{1'b1}}};
			default: div_num = '0;
		endcase
		case (cmd.div_den)
			DD_PT:     div_den = pt_q;
			DD_RATE:   div_den = {{(DEN_W-RATE_W){1'b0}}, rate_q};
			DD_PERIOD: div_den = {{(DEN_W-PER_W){1'b0}}, period_q};
			default:   div_den = '0;
		endcase
	end

	aptc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.acc    (acc)
	);

	aptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		stat.mode      = mode_q;
		stat.rs_ok     = (now_q > anchor_q) && p_nz && t_nz;
		stat.q_ok      = p_nz && t_nz && r_nz && !nxt_sum[TIME_W];
		// boundary must fit in 64 bits before it can be reached
		stat.adv_ok    = (quo[NUM_W-1:TIME_W] == '0) && !bnd_sum[TIME_W] &&
		                 (now_q >= bnd_sum[TIME_W-1:0]);
		stat.s_ovf     = acc[ACC_W-1:TIME_W] != '0;
		stat.rate_zero = !r_nz;
		stat.mul_done  = mul_done;
		stat.div_done  = div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= ANCHOR_RST;
			ticks_q  <= TICKS_RST;
			rate_q   <= RATE_RST;
			period_q <= PERIOD_RST;
			pub_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ANCHOR: anchor_q <= cfg_wdata;
				REG_TICKS:  ticks_q  <= cfg_wdata[TICK_W-1:0];
				REG_RATE:   rate_q   <= cfg_wdata[RATE_W-1:0];
				REG_PERIOD: period_q <= cfg_wdata[PER_W-1:0];
				default:    anchor_q <= anchor_q;
			endcase
			pub_q <= '0;
		end else if (cmd.adv_commit) begin
			pub_q <= nxt_sum[TIME_W-1:0];
		end else if (cmd.rs_commit && (target > pub_q)) begin
			pub_q <= target;
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ANCHOR: cfg_rdata = anchor_q;
			REG_TICKS:  cfg_rdata = {{(DATA_W-TICK_W){1'b0}}, ticks_q};
			REG_RATE:   cfg_rdata = {{(DATA_W-RATE_W){1'b0}}, rate_q};
			REG_PERIOD: cfg_rdata = {{(DATA_W-PER_W){1'b0}}, period_q};
			default:    cfg_rdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode;
			now_q  <= current_host_time;
			adv_q  <= 1'b0;
		end else if (cmd.adv_commit) begin
			adv_q <= 1'b1;
		end
		if (cmd.pt_load)
			pt_q <= acc[DEN_W-1:0];
		if (cmd.out_load) begin
			sample_q   <= pub_q;
			host_q     <= r_nz ? anchor_q + quo[TIME_W-1:0] : anchor_q;
			advanced_q <= adv_q;
		end
	end

	assign sample_time = sample_q;
	assign host_time   = host_q;
	assign advanced    = advanced_q;

endmodule

// ----- design/aptc_ctrl.sv -----
// ----------------------------------------------------------------------------
// aptc_ctrl
// Sequencer for resync and query transactions; owns the input and output
// handshakes.
// ----------------------------------------------------------------------------
module aptc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  aptc_pkg::stat_t stat,
	output aptc_pkg::cmd_t  cmd
);
	import aptc_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n        = state_q;
		cmd.load_in    = 1'b0;
		cmd.mul_start  = 1'b0;
		cmd.mul_a      = MA_CUR;
		cmd.mul_b      = MB_TICKS;
		cmd.div_start  = 1'b0;
		cmd.div_num    = DN_ACC;
		cmd.div_den    = DD_RATE;
		cmd.pt_load    = 1'b0;
		cmd.rs_commit  = 1'b0;
		cmd.adv_commit = 1'b0;
		cmd.out_load   = 1'b0;
		in_stall       = state_q != ST_IDLE;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!stat.mode) begin
					if (stat.rs_ok) begin
						cmd.mul_start = 1'b1;
						cmd.mul_a     = MA_TICKS;
						cmd.mul_b     = MB_PERIOD;
						state_n       = ST_PT_MUL;
					end else begin
						state_n = ST_IDLE;
					end
				end else if (stat.q_ok) begin
					cmd.mul_start = 1'b1;
					cmd.mul_a     = MA_NXT;
					cmd.mul_b     = MB_TICKS;
					state_n       = ST_Q_MUL;
				end else if (!stat.rate_zero) begin
					state_n = ST_H_START;
				end else begin
					state_n = ST_OUT_WAIT;
				end
			end
			// resync: floor((now-anchor)*R/(P*T))*P
			ST_PT_MUL: begin
				if (stat.mul_done) begin
					cmd.pt_load   = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_a     = MA_DIFF;
					cmd.mul_b     = MB_RATE;
					state_n       = ST_D_MUL;
				end
			end
			ST_D_MUL: begin
				if (stat.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_num   = DN_ACC;
					cmd.div_den   = DD_PT;
					state_n       = ST_I_DIV;
				end
			end
			ST_I_DIV: begin
				if (stat.div_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_a     = MA_QUO;
					cmd.mul_b     = MB_PERIOD;
					state_n       = ST_S_MUL;
				end
			end
			ST_S_MUL: begin
				if (stat.mul_done) begin
					if (stat.s_ovf) begin
						// saturate to the largest multiple of P in 64 bits
						cmd.div_start = 1'b1;
						cmd.div_num   = DN_ONES;
						cmd.div_den   = DD_PERIOD;
						state_n       = ST_SAT_DIV;
					end else begin
						cmd.rs_commit = 1'b1;
						state_n       = ST_IDLE;
					end
				end
			end
			ST_SAT_DIV: begin
				if (stat.div_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_a     = MA_QUO;
					cmd.mul_b     = MB_PERIOD;
					state_n       = ST_SAT_MUL;
				end
			end
			ST_SAT_MUL: begin
				if (stat.mul_done) begin
					cmd.rs_commit = 1'b1;
					state_n       = ST_IDLE;
				end
			end
			// query: next boundary at anchor + floor((cur+P)*T/R)
			ST_Q_MUL: begin
				if (stat.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_num   = DN_ACC;
					cmd.div_den   = DD_RATE;
					state_n       = ST_Q_DIV;
				end
			end
			ST_Q_DIV: begin
				if (stat.div_done)
					state_n = ST_Q_CHECK;
			end
			ST_Q_CHECK: begin
				cmd.adv_commit = stat.adv_ok;
				state_n        = ST_H_START;
			end
			// host time of the (possibly updated) sample time
			ST_H_START: begin
				cmd.mul_start = 1'b1;
				cmd.mul_a     = MA_CUR;
				cmd.mul_b     = MB_TICKS;
				state_n       = ST_H_MUL;
			end
			ST_H_MUL: begin
				if (stat.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_num   = DN_ACC;
					cmd.div_den   = DD_RATE;
					state_n       = ST_H_DIV;
				end
			end
			ST_H_DIV: begin
				if (stat.div_done)
					state_n = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (!ovalid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = ovalid_q;

endmodule

// ----- design/audio_period_timestamp_clock_top.sv -----
// ----------------------------------------------------------------------------
// audio_period_timestamp_clock_top
// Period-aligned sample time against a host tick clock, with APB registers.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A query runs two multiply/divide
// passes when a period step is possible, one when it is not, and none when
// the sample rate is zero; a resync does no arithmetic when it has nothing
// to do, runs three multiplies and one divide normally, and one more divide
// and multiply when the target saturates. The shared bit-serial divider
// yields one quotient bit per cycle over a 96-bit dividend. A finished
// result waits in the output register, and the next transaction is
// accepted and worked on meanwhile; a query result is held back while the
// previous one is still stalled. Registers sit at byte address 8*i with
// 64-bit data; any write clears the sample time.
// ----------------------------------------------------------------------------
module audio_period_timestamp_clock_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aptc_pkg::ADDR_W-1:0] paddr,
	input  logic [aptc_pkg::DATA_W-1:0] pwdata,
	output logic [aptc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [aptc_pkg::TIME_W-1:0] current_host_time,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [aptc_pkg::TIME_W-1:0] sample_time,
	output logic [aptc_pkg::TIME_W-1:0] host_time,
	output logic                        advanced
);
	import aptc_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	aptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	aptc_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (paddr[ADDR_W-1:3]),
		.cfg_wdata         (pwdata),
		.cfg_rdata         (prdata),
		.mode              (mode),
		.current_host_time (current_host_time),
		.cmd               (cmd),
		.stat              (stat),
		.sample_time       (sample_time),
		.host_time         (host_time),
		.advanced          (advanced)
	);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the audio period timestamp clock. Resync and query
// transactions go in through the stream port under changing register
// settings and idle patterns. A built-in predictor, using exact 128-bit
// integer math, works out each query result and checks the result fields
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import aptc_pkg::*;

	localparam logic MODE_RESYNC = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	localparam logic [TIME_W-1:0] ALL_ONES = '1;
	localparam int NUM_PHASES    = 16;
	localparam int SETTLE_CYCLES = 400;
	localparam int LIMIT_CYCLES  = 1000000;

	typedef struct packed {
		logic [TIME_W-1:0] anchor;
		logic [TICK_W-1:0] ticks;
		logic [RATE_W-1:0] rate;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] samples;
	} clock_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] sample_time;
		logic [TIME_W-1:0] host_time;
		logic              advanced;
	} stamp_t;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] now;
	} stim_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              mode = MODE_RESYNC;
	logic [TIME_W-1:0] current_host_time = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [TIME_W-1:0] sample_time;
	logic [TIME_W-1:0] host_time;
	logic              advanced;

	clock_state_t dut_clock, plan_clock;
	stim_t        pending_items[$];
	stamp_t       expected_stamps[$];
	stim_t        drv_item;
	stamp_t       new_stamp, want_stamp, seen_stamp;
	logic         new_has_stamp;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           items_queued = 0;
	int           items_sent = 0;
	int           items_accepted = 0;
	int           mismatches = 0;
	int           cycles = 0;

	audio_period_timestamp_clock_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.mode              (mode),
		.current_host_time (current_host_time),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.sample_time       (sample_time),
		.host_time         (host_time),
		.advanced          (advanced)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// anchor + floor(frames*T/R), wrapped; top bit set when the sum fits in 64 bits, clear for a zero rate
	function automatic logic [TIME_W:0] frames_to_host(clock_state_t st,
			logic [TIME_W-1:0] frames);
		logic [127:0] quo;
		if (st.rate == 0)
			return {1'b0, st.anchor};
		quo = 128'(frames) * 128'(st.ticks) / 128'(st.rate);
		return {(quo[127:64] == 0) && (quo[63:0] <= ~st.anchor), st.anchor + quo[63:0]};
	endfunction

	task automatic advance_clock(inout clock_state_t st, input logic md,
			input logic [TIME_W-1:0] now, output logic has_stamp, output stamp_t stamp);
		logic [TIME_W-1:0] span, target, cur;
		logic [127:0]      scaled;
		logic [TIME_W:0]   bnd;
		logic              adv;
		has_stamp = 1'b0;
		stamp = '0;
		if (md == MODE_RESYNC) begin
			target = '0;
			if (now > st.anchor && st.period != 0 && st.ticks != 0) begin
				span = now - st.anchor;
				scaled = (128'(span) * 128'(st.rate) / (128'(st.period) * 128'(st.ticks)))
					* 128'(st.period);
				// saturate to the last whole period below 2^64
				if (scaled[127:64] != 0)
					target = (ALL_ONES / 64'(st.period)) * 64'(st.period);
				else
					target = scaled[63:0];
			end
			if (target > st.samples)
				st.samples = target;
		end else begin
			cur = st.samples;
			adv = 1'b0;
			if (st.period != 0 && st.ticks != 0 && st.rate != 0
					&& cur <= ALL_ONES - 64'(st.period)) begin
				bnd = frames_to_host(st, cur + 64'(st.period));
				if (bnd[TIME_W] && now >= bnd[TIME_W-1:0]) begin
					cur = cur + 64'(st.period);
					adv = 1'b1;
					st.samples = cur;
				end
			end
			bnd = frames_to_host(st, cur);
			stamp.sample_time = cur;
			stamp.host_time = bnd[TIME_W-1:0];
			stamp.advanced = adv;
			has_stamp = 1'b1;
		end
	endtask

	function automatic clock_state_t with_reg(clock_state_t st, logic [IDX_W-1:0] idx,
			logic [DATA_W-1:0] val);
		case (idx)
			REG_ANCHOR: st.anchor = val[TIME_W-1:0];
			REG_TICKS:  st.ticks = val[TICK_W-1:0];
			REG_RATE:   st.rate = val[RATE_W-1:0];
			REG_PERIOD: st.period = val[PER_W-1:0];
			default: ;
		endcase
		st.samples = '0;
		return st;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dut_clock = with_reg(dut_clock, idx, val);
		plan_clock = with_reg(plan_clock, idx, val);
	endtask

	function automatic logic [TIME_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_item(logic md, logic [TIME_W-1:0] now);
		stamp_t scratch_stamp;
		logic   scratch_has;
		pending_items.push_back({md, now});
		advance_clock(plan_clock, md, now, scratch_has, scratch_stamp);
		items_queued++;
	endtask

	// mostly host times right at a period boundary, as seen from the planned state
	task automatic queue_random_item();
		logic [TIME_W:0]   bnd;
		logic [TIME_W-1:0] frames, now, nudge;
		logic              md;
		int                pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			md = MODE_QUERY;
			frames = plan_clock.samples + 64'(plan_clock.period);
		end else if (pick < 65) begin
			md = MODE_QUERY;
			frames = plan_clock.samples;
		end else if (pick < 85) begin
			md = MODE_RESYNC;
			frames = plan_clock.samples + 64'(plan_clock.period) * 64'($urandom_range(8));
		end else begin
			md = 1'($urandom_range(1));
			frames = '0;
		end
		bnd = frames_to_host(plan_clock, frames);
		if (pick >= 85 || !bnd[TIME_W]) begin
			now = rand64();
		end else begin
			if ($urandom_range(1))
				nudge = 64'($urandom_range(6)) - 64'd3;
			else if ($urandom_range(1))
				nudge = 64'($urandom_range(1 << 20));
			else
				nudge = -64'($urandom_range(1 << 20));
			now = bnd[TIME_W-1:0] + nudge;
		end
		queue_item(md, now);
	endtask

	task automatic configure_phase(int ph);
		case (ph)
			0: ;
			1: begin
				write_reg(REG_ANCHOR, '0);
				write_reg(REG_TICKS, 64'd1);
				write_reg(REG_RATE, 64'd1048576);
				write_reg(REG_PERIOD, 64'd1000);
			end
			2: begin
				write_reg(REG_TICKS, 64'hFFFF_FFFF);
				write_reg(REG_RATE, 64'd1);
				write_reg(REG_PERIOD, 64'd65535);
			end
			3: begin
				write_reg(REG_ANCHOR, ALL_ONES - 64'd100);
				write_reg(REG_TICKS, 64'd24000000);
				write_reg(REG_RATE, 64'd48000);
				write_reg(REG_PERIOD, 64'd512);
			end
			4: begin
				write_reg(REG_ANCHOR, '0);
				write_reg(REG_PERIOD, '0);
			end
			5: begin
				write_reg(REG_PERIOD, 64'd512);
				write_reg(REG_TICKS, '0);
			end
			6: begin
				write_reg(REG_TICKS, 64'd24000000);
				write_reg(REG_RATE, '0);
			end
			7: begin
				write_reg(REG_RATE, 64'h1F_FFFF);
				write_reg(REG_ANCHOR, {32'd0, $urandom});
			end
			default: begin
				case ($urandom_range(3))
					0: write_reg(REG_ANCHOR, '0);
					1: write_reg(REG_ANCHOR, {32'd0, $urandom});
					2: write_reg(REG_ANCHOR, rand64());
					default: write_reg(REG_ANCHOR, ALL_ONES - 64'($urandom));
				endcase
				case ($urandom_range(2))
					0: write_reg(REG_TICKS, 64'd24000000);
					1: write_reg(REG_TICKS, 64'($urandom_range(100000000, 1000000)));
					default: write_reg(REG_TICKS, 64'($urandom));
				endcase
				case ($urandom_range(4))
					0: write_reg(REG_RATE, 64'd44100);
					1: write_reg(REG_RATE, 64'd48000);
					2: write_reg(REG_RATE, 64'd96000);
					3: write_reg(REG_RATE, 64'd192000);
					default: write_reg(REG_RATE, 64'($urandom_range(1048576, 1)));
				endcase
				case ($urandom_range(3))
					0: write_reg(REG_PERIOD, 64'd256);
					1: write_reg(REG_PERIOD, 64'd480);
					2: write_reg(REG_PERIOD, 64'd1024);
					default: write_reg(REG_PERIOD, 64'($urandom_range(65535, 1)));
				endcase
			end
		endcase
	endtask

	task automatic directed_items(int ph);
		case (ph)
			// reset values: one period is 256000 ticks
			0: begin
				queue_item(MODE_QUERY, 64'd0);
				queue_item(MODE_QUERY, 64'd255999);
				queue_item(MODE_QUERY, 64'd256000);
				queue_item(MODE_QUERY, 64'd256000);
				queue_item(MODE_QUERY, ALL_ONES);
				queue_item(MODE_RESYNC, 64'd0);
				queue_item(MODE_RESYNC, 64'd10000000);
				queue_item(MODE_QUERY, 64'd0);
				queue_item(MODE_RESYNC, 64'd5);
				queue_item(MODE_QUERY, 64'd0);
			end
			// resync target past 64 bits, then a step that would overflow
			1: begin
				queue_item(MODE_RESYNC, 64'h8000_0000_0000_0000);
				queue_item(MODE_QUERY, ALL_ONES);
				queue_item(MODE_QUERY, 64'd0);
			end
			// next boundary quotient wider than 64 bits
			2: begin
				queue_item(MODE_RESYNC, ALL_ONES);
				queue_item(MODE_QUERY, ALL_ONES);
			end
			// anchor near the top: boundary sum does not fit
			3: begin
				queue_item(MODE_QUERY, ALL_ONES);
				queue_item(MODE_RESYNC, ALL_ONES);
				queue_item(MODE_RESYNC, ALL_ONES - 64'd200);
			end
			4, 5: begin
				queue_item(MODE_RESYNC, ALL_ONES);
				queue_item(MODE_QUERY, ALL_ONES);
			end
			6: begin
				queue_item(MODE_QUERY, ALL_ONES);
				queue_item(MODE_RESYNC, ALL_ONES);
				queue_item(MODE_QUERY, 64'd0);
			end
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (items_accepted != items_queued || expected_stamps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stream driver: a new transaction only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && items_sent == items_accepted) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				drv_item = pending_items.pop_front();
				mode <= drv_item.mode;
				current_host_time <= drv_item.now;
				in_valid <= 1'b1;
				items_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			advance_clock(dut_clock, mode, current_host_time, new_has_stamp, new_stamp);
			if (new_has_stamp)
				expected_stamps.push_back(new_stamp);
			items_accepted++;
		end
		if (arst_n && out_valid && !out_stall) begin
			seen_stamp.sample_time = sample_time;
			seen_stamp.host_time = host_time;
			seen_stamp.advanced = advanced;
			if (expected_stamps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: sample_time=%0d host_time=%0d advanced=%0b",
						sample_time, host_time, advanced);
			end else begin
				want_stamp = expected_stamps.pop_front();
				if (seen_stamp.sample_time != want_stamp.sample_time
						|| seen_stamp.host_time != want_stamp.host_time
						|| seen_stamp.advanced != want_stamp.advanced) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch (exp/got): st %0d/%0d ht %0d/%0d adv %0b/%0b",
							want_stamp.sample_time, seen_stamp.sample_time,
							want_stamp.host_time, seen_stamp.host_time,
							want_stamp.advanced, seen_stamp.advanced);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		dut_clock = '{ANCHOR_RST, TICKS_RST, RATE_RST, PERIOD_RST, 64'd0};
		plan_clock = dut_clock;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 59; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 59; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			configure_phase(ph);
			directed_items(ph);
			for (int n = 0; n < (ph < 8 ? 45 : 50); n++) begin
				// hold the sender once until everything in flight has come back
				if (ph == 9 && n == 25)
					wait_idle();
				queue_random_item();
			end
			wait_idle();
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/aptc_pkg.sv
design/aptc_mul.sv
design/aptc_div.sv
design/aptc_dpath.sv
design/aptc_ctrl.sv
design/audio_period_timestamp_clock_top.sv
verif/tb.sv
